[design/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define COCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define COCD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COCD_ASSERT(label, clk, rst, prop, msg)
`define COCD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[design/cocd_pkg.sv]
// Types, operation codes and the classification function of the opcode class decoder.
`timescale 1ns / 1ps
package cocd_pkg;

   typedef logic [15:0] word_type;
   typedef logic [2:0]  count_type;
   typedef logic [6:0]  op_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNK   = 2'd1,
      ST_INV   = 2'd2,
      ST_SHORT = 2'd3
   } status_type;

   typedef struct packed {
      op_code_type op;
      status_type  status;
   } result_type;

   // Operation kinds, numbered densely in order of first appearance.
   typedef enum logic [6:0] {
      OP_NONE = 7'd0,
      OP_BTST, OP_BCHG, OP_BCLR, OP_BSET, OP_CAS2, OP_CAS, OP_CHK2, OP_CMP2,
      OP_ORI, OP_ANDI, OP_SUBI, OP_ADDI, OP_EORI, OP_CMPI, OP_MOVES,
      OP_MOVEA, OP_MOVE, OP_EXTB, OP_LEA, OP_CHK, OP_TRAP, OP_UNLK, OP_LINK,
      OP_MOVEC, OP_RESET, OP_NOP, OP_STOP, OP_RTE, OP_RTD, OP_RTS, OP_JSR,
      OP_JMP, OP_ILLEGAL, OP_TAS, OP_TST, OP_EXT, OP_MOVEM, OP_DIVS, OP_MULS,
      OP_DIVU, OP_MULU, OP_SWAP, OP_BKPT, OP_PEA, OP_NBCD, OP_NEGX, OP_CLR,
      OP_NEG, OP_NOT, OP_DBCC, OP_TRAPCC, OP_SCC, OP_SUBQ, OP_ADDQ, OP_BRA,
      OP_BSR, OP_TRAPV, OP_RTR, OP_BCC, OP_MOVEQ, OP_ABCD, OP_SBCD, OP_EXG,
      OP_PACK, OP_UNPK, OP_AND, OP_OR, OP_ADDA, OP_ADDX, OP_ADD, OP_SUBA,
      OP_SUBX, OP_SUB, OP_CMPA, OP_CMPM, OP_EOR, OP_CMP,
      OP_ASL_M, OP_LSL_M, OP_ROXL_M, OP_ROL_M,
      OP_ASL_R, OP_LSL_R, OP_ROXL_R, OP_ROL_R,
      OP_ASR_M, OP_LSR_M, OP_ROXR_M, OP_ROR_M,
      OP_ASR_R, OP_LSR_R, OP_ROXR_R, OP_ROR_R,
      OP_PMOVE_RD, OP_PMOVE_WR, OP_PFLUSHA, OP_PFLUSH, OP_PTEST_RD, OP_PTEST_WR,
      OP_PLOAD_RD, OP_PLOAD_WR, OP_CPGEN, OP_CPDBCC, OP_CPTRAPCC, OP_CPSCC,
      OP_CPBCC, OP_CPSAVE, OP_CPRESTORE
   } op_type;

   localparam logic [5:0] ILLEGAL_LOW = 6'b111100;
   localparam logic [7:0] DISP_TRAPV  = 8'h76;
   localparam logic [7:0] DISP_RTR    = 8'h77;
   localparam logic [7:0] DISP_LONG   = 8'hFF;
   localparam logic [2:0] GROUP_BIT   = 3'b100;

   function automatic result_type ok_fn(input op_code_type op);
      result_type r;
      r.op = op;
      r.status = ST_OK;
      return r;
   endfunction

   function automatic result_type err_fn(input status_type st);
      result_type r;
      r.op = 7'(OP_NONE);
      r.status = st;
      return r;
   endfunction

   function automatic op_code_type opc(input op_type op);
      return op_code_type'(op);
   endfunction

   function automatic result_type classify_fn(input word_type w0, input word_type w1,
                                              input count_type n);
      logic [2:0]  need;
      op_code_type base;
      if (n < 3'd1) return err_fn(ST_SHORT);
      unique case (w0[15:12])
         4'h0: begin
            if (({2'b00, w0[8]} ^ w0[11:9]) == GROUP_BIT) begin
               if (w0[11:9] == GROUP_BIT && n < 3'd2) return err_fn(ST_SHORT);
               return ok_fn(opc(OP_BTST) + {5'd0, w0[7:6]});
            end
            if (w0[7:6] == 2'd3) begin
               if (w0[11]) begin
                  if (w0[5:3] == 3'd7) begin
                     if (n < 3'd3) return err_fn(ST_SHORT);
                     return ok_fn(opc(OP_CAS2));
                  end
                  if (n < 3'd2) return err_fn(ST_SHORT);
                  return ok_fn(opc(OP_CAS));
               end
               if (n < 3'd2) return err_fn(ST_SHORT);
               if (w0[10:9] == 2'd3) return err_fn(ST_INV);
               return ok_fn(w1[11] ? opc(OP_CHK2) : opc(OP_CMP2));
            end
            need = ((w0[7:6] == 2'd0) ? 3'd1 : {1'b0, w0[7:6]}) + 3'd1;
            unique case (w0[11:9])
               3'd0: return (n < need) ? err_fn(ST_SHORT) : ok_fn(opc(OP_ORI));
               3'd1: return (n < need) ? err_fn(ST_SHORT) : ok_fn(opc(OP_ANDI));
               3'd2: return (n < need) ? err_fn(ST_SHORT) : ok_fn(opc(OP_SUBI));
               3'd3: return (n < need) ? err_fn(ST_SHORT) : ok_fn(opc(OP_ADDI));
               3'd5: return (n < need) ? err_fn(ST_SHORT) : ok_fn(opc(OP_EORI));
               3'd6: return (n < need) ? err_fn(ST_SHORT) : ok_fn(opc(OP_CMPI));
               3'd7: return (n < 3'd2) ? err_fn(ST_SHORT) : ok_fn(opc(OP_MOVES));
               default: return err_fn(ST_UNK);
            endcase
         end
         4'h1, 4'h2, 4'h3:
            return ok_fn((w0[8:6] == 3'd1) ? opc(OP_MOVEA) : opc(OP_MOVE));
         4'h4: begin
            if (w0[8]) begin
               if (w0[7:6] == 2'd3)
                  return ok_fn((w0[5:3] == 3'd0) ? opc(OP_EXTB) : opc(OP_LEA));
               if (!w0[6]) return ok_fn(opc(OP_CHK));
               return err_fn(ST_UNK);
            end
            if (w0[11]) begin
               if (w0[9]) begin
                  if (w0[10]) begin
                     unique case (w0[7:6])
                        2'd1: begin
                           unique case (w0[5:4])
                              2'd0: return ok_fn(opc(OP_TRAP));
                              2'd1: begin
                                 if (w0[3]) return ok_fn(opc(OP_UNLK));
                                 if (n < 3'd2) return err_fn(ST_SHORT);
                                 return ok_fn(opc(OP_LINK));
                              end
                              2'd2: return ok_fn(opc(OP_MOVE));
                              default: begin
                                 if (w0[3]) begin
                                    if (w0[2:1] == 2'd1) begin
                                       if (n < 3'd2) return err_fn(ST_SHORT);
                                       return ok_fn(opc(OP_MOVEC));
                                    end
                                    return err_fn(ST_UNK);
                                 end
                                 unique case (w0[2:0])
                                    3'd0: return ok_fn(opc(OP_RESET));
                                    3'd1: return ok_fn(opc(OP_NOP));
                                    3'd2: return (n < 3'd2) ? err_fn(ST_SHORT)
                                                            : ok_fn(opc(OP_STOP));
                                    3'd3: return ok_fn(opc(OP_RTE));
                                    3'd4: return (n < 3'd2) ? err_fn(ST_SHORT)
                                                            : ok_fn(opc(OP_RTD));
                                    3'd5: return ok_fn(opc(OP_RTS));
                                    default: return err_fn(ST_UNK);
                                 endcase
                              end
                           endcase
                        end
                        2'd2: return ok_fn(opc(OP_JSR));
                        2'd3: return ok_fn(opc(OP_JMP));
                        default: return err_fn(ST_UNK);
                     endcase
                  end
                  if (w0[7:6] == 2'd3)
                     return ok_fn((w0[5:0] == ILLEGAL_LOW) ? opc(OP_ILLEGAL) : opc(OP_TAS));
                  return ok_fn(opc(OP_TST));
               end
               if (w0[7]) begin
                  if (w0[5:3] == 3'd0) return ok_fn(opc(OP_EXT));
                  if (n < 3'd2) return err_fn(ST_SHORT);
                  return ok_fn(opc(OP_MOVEM));
               end
               if (w0[10]) begin
                  if (n < 3'd2) return err_fn(ST_SHORT);
                  if (w1[11]) return ok_fn(w0[6] ? opc(OP_DIVS) : opc(OP_MULS));
                  return ok_fn(w0[6] ? opc(OP_DIVU) : opc(OP_MULU));
               end
               if (w0[6]) begin
                  unique case (w0[5:3])
                     3'd0: return ok_fn(opc(OP_SWAP));
                     3'd1: return ok_fn(opc(OP_BKPT));
                     default: return ok_fn(opc(OP_PEA));
                  endcase
               end
               if (w0[5:3] == 3'd1) begin
                  if (n < 3'd3) return err_fn(ST_SHORT);
                  return ok_fn(opc(OP_LINK));
               end
               return ok_fn(opc(OP_NBCD));
            end
            if (w0[7:6] == 2'd3) return ok_fn(opc(OP_MOVE));
            return ok_fn(opc(OP_NEGX) + {5'd0, w0[10:9]});
         end
         4'h5: begin
            if (w0[7:6] == 2'd3) begin
               unique case (w0[5:3])
                  3'd1: return (n < 3'd2) ? err_fn(ST_SHORT) : ok_fn(opc(OP_DBCC));
                  3'd7: begin
                     unique case (w0[2:0])
                        3'd2: return (n < 3'd2) ? err_fn(ST_SHORT) : ok_fn(opc(OP_TRAPCC));
                        3'd3: return (n < 3'd3) ? err_fn(ST_SHORT) : ok_fn(opc(OP_TRAPCC));
                        3'd4: return ok_fn(opc(OP_TRAPCC));
                        default: return err_fn(ST_UNK);
                     endcase
                  end
                  default: return ok_fn(opc(OP_SCC));
               endcase
            end
            return ok_fn(w0[8] ? opc(OP_SUBQ) : opc(OP_ADDQ));
         end
         4'h6: begin
            if (w0[11:8] == 4'd14) begin
               if (w0[7:0] == DISP_TRAPV) return ok_fn(opc(OP_TRAPV));
               if (w0[7:0] == DISP_RTR) return ok_fn(opc(OP_RTR));
               return err_fn(ST_UNK);
            end
            if (w0[7:0] == 8'd0 && n < 3'd2) return err_fn(ST_SHORT);
            if (w0[7:0] == DISP_LONG && n < 3'd3) return err_fn(ST_SHORT);
            if (w0[11:8] == 4'd0) return ok_fn(opc(OP_BRA));
            if (w0[11:8] == 4'd1) return ok_fn(opc(OP_BSR));
            return ok_fn(opc(OP_BCC));
         end
         4'h7:
            return w0[8] ? err_fn(ST_UNK) : ok_fn(opc(OP_MOVEQ));
         4'h8, 4'hC: begin
            if (w0[7:6] == 2'd3) begin
               if (w0[8]) return ok_fn(w0[14] ? opc(OP_MULS) : opc(OP_DIVS));
               return ok_fn(w0[14] ? opc(OP_MULU) : opc(OP_DIVU));
            end
            if (w0[10] && w0[5:4] == 2'd0) begin
               if (w0[8:6] == 3'd4) return ok_fn(w0[14] ? opc(OP_ABCD) : opc(OP_SBCD));
               if (w0[14]) return w0[8] ? ok_fn(opc(OP_EXG)) : err_fn(ST_UNK);
               unique case (w0[8:6])
                  3'd5: return (n < 3'd2) ? err_fn(ST_SHORT) : ok_fn(opc(OP_PACK));
                  3'd6: return (n < 3'd2) ? err_fn(ST_SHORT) : ok_fn(opc(OP_UNPK));
                  default: return err_fn(ST_UNK);
               endcase
            end
            return ok_fn(w0[14] ? opc(OP_AND) : opc(OP_OR));
         end
         4'h9, 4'hD: begin
            base = w0[14] ? opc(OP_ADDA) : opc(OP_SUBA);
            if (w0[7:6] == 2'd3) return ok_fn(base);
            if (w0[5:4] == 2'd0 && w0[8]) return ok_fn(base + 7'd1);
            return ok_fn(base + 7'd2);
         end
         4'hB: begin
            if (w0[7:6] == 2'd3) return ok_fn(opc(OP_CMPA));
            if (w0[8]) return ok_fn((w0[5:3] == 3'd1) ? opc(OP_CMPM) : opc(OP_EOR));
            return ok_fn(opc(OP_CMP));
         end
         4'hE: begin
            if (w0[7:6] == 2'd3) begin
               if (w0[11]) begin
                  if (n < 3'd2) return err_fn(ST_SHORT);
                  base = w0[8] ? opc(OP_ASL_M) : opc(OP_ASR_M);
                  return ok_fn(base + {5'd0, w0[10:9]});
               end
               base = w0[8] ? opc(OP_ASL_R) : opc(OP_ASR_R);
               return ok_fn(base + {5'd0, w0[10:9]});
            end
            base = w0[8] ? opc(OP_ASL_R) : opc(OP_ASR_R);
            return ok_fn(base + {5'd0, w0[4:3]});
         end
         4'hF: begin
            if (w0[11:9] == 3'd0) begin
               if (n < 3'd2) return err_fn(ST_SHORT);
               if (w0[8:6] != 3'd0) return err_fn(ST_UNK);
               unique case (w1[15:13])
                  3'd1: begin
                     if (w1[12:10] == 3'd0)
                        return ok_fn(w1[9] ? opc(OP_PMOVE_RD) : opc(OP_PMOVE_WR));
                     if (w1[7:5] == 3'd1) return ok_fn(opc(OP_PFLUSHA));
                     return ok_fn(opc(OP_PFLUSH));
                  end
                  3'd2: return ok_fn(w1[8] ? opc(OP_PTEST_RD) : opc(OP_PTEST_WR));
                  3'd4: return ok_fn(w1[9] ? opc(OP_PLOAD_RD) : opc(OP_PLOAD_WR));
                  default: return err_fn(ST_UNK);
               endcase
            end
            unique case (w0[8:6])
               3'd0: return ok_fn(opc(OP_CPGEN));
               3'd1: begin
                  if (n < 3'd2) return err_fn(ST_SHORT);
                  unique case (w0[5:3])
                     3'd1: return ok_fn(opc(OP_CPDBCC));
                     3'd7: return ok_fn(opc(OP_CPTRAPCC));
                     default: return ok_fn(opc(OP_CPSCC));
                  endcase
               end
               3'd2, 3'd3: return ok_fn(opc(OP_CPBCC));
               3'd4: return ok_fn(opc(OP_CPSAVE));
               3'd5: return ok_fn(opc(OP_CPRESTORE));
               default: return err_fn(ST_UNK);
            endcase
         end
         default: return err_fn(ST_UNK);
      endcase
   endfunction

endpackage

[design/cisc_opcode_class_decoder.sv]
// Top level of the opcode class decoder: input register, classification logic, result register.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  first_word, second_word, words_available
//   rsp_      out        rsp_valid/rsp_ready  operation, status
//
// The block takes one instruction every cycle while its responses are being accepted.
// An item sits in the input register while the classification logic works on it, and
// moves into the result register, which presents the answer, once that register is free.
// Reset clears both valid bits; payload registers are not reset.
// When the result register is held by a stalled consumer, the input register
// still takes one more transfer, and req_ready drops only when both are full.
`include "assert_macros.svh"

module cisc_opcode_class_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cocd_pkg::word_type    req_first_word,
   input  cocd_pkg::word_type    req_second_word,
   input  cocd_pkg::count_type   req_words_available,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cocd_pkg::op_code_type rsp_operation,
   output logic [1:0]            rsp_status
);
   import cocd_pkg::*;

   // Input register stage.
   logic        in_valid_ff, in_valid_in;
   word_type    first_ff, first_in;
   word_type    second_ff, second_in;
   count_type   count_ff, count_in;

   // Result register stage.
   logic        out_valid_ff, out_valid_in;
   result_type  result_ff, result_in;

   logic        out_free;
   logic        advance;
   result_type  decoded;

   // The result register can take a new value when it is empty or being drained.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   // The whole classification tree sits between the two registers.
   assign decoded = classify_fn(first_ff, second_ff, count_ff);

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      count_in     = count_ff;
      if (req_valid && req_ready) begin
         first_in  = req_first_word;
         second_in = req_second_word;
         count_in  = req_words_available;
      end
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
      result_in    = advance ? decoded : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
      count_ff  <= count_in;
      result_ff <= result_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_operation = result_ff.op;
   assign rsp_status    = result_ff.status;

   // A non-ok status always comes with operation zero.
   `COCD_ASSERT(a_err_op_zero, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_operation == 7'd0, "error status with nonzero operation")
   // An ok result names a real operation kind.
   `COCD_ASSERT(a_ok_op_range, clock, reset, rsp_valid && rsp_status == ST_OK |-> rsp_operation != 7'd0 && rsp_operation <= 7'(OP_CPRESTORE), "ok status with operation out of range")
   // An item in the input register moves into a free result register on the next clock edge.
   `COCD_ASSERT(a_advance, clock, reset, in_valid_ff && out_free |=> rsp_valid, "decoded item not presented")
   // Nothing is presented in the cycle after reset.
   `COCD_ASSERT_ALWAYS(a_reset_clear, clock, !reset && $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

[bench/testbench.sv]
// Self-checking testbench for the opcode class decoder, with random handshake gaps on both channels.
`timescale 1ns / 1ps

module testbench;
   import cocd_pkg::*;

   // One predicted classification: the operation kind and the status.
   typedef struct packed {
      op_type     kind;
      status_type st;
   } decode_type;

   // An accepted request and the classification it must produce, kept in
   // transfer order until the matching response transfer arrives.
   typedef struct {
      word_type   w;
      word_type   x;
      count_type  n;
      decode_type want;
   } pending_decode_type;

   // The scoreboard predicts the classification of every accepted request
   // and compares each response transfer with the oldest prediction.
   class opclass_scoreboard;
      pending_decode_type pending[$];
      int unsigned        mismatches;
      int unsigned        accepted;

      function decode_type kind_ok(op_type k);
         return '{kind: k, st: ST_OK};
      endfunction

      function decode_type kind_fail(status_type s);
         return '{kind: OP_NONE, st: s};
      endfunction

      // Walks the opcode tree. Length checks sit exactly where the tree
      // tests them, so a short instruction can still be rejected earlier
      // as unknown or invalid.
      function decode_type classify_opcode(word_type w, word_type x, count_type n);
         op_type     base;
         logic [2:0] need;
         if (n == 3'd0) return kind_fail(ST_SHORT);
         case (w[15:12])
            4'h0: begin
               // The bit-operation test compares bit 8 XOR bits 11..9 with four,
               // which picks static forms and dynamic forms on register five only.
               if ((w[11:9] ^ {2'b00, w[8]}) == 3'd4) begin
                  if (w[11:9] == 3'd4 && n < 2) return kind_fail(ST_SHORT);
                  return kind_ok(op_type'(OP_BTST + w[7:6]));
               end
               if (w[7:6] == 2'd3) begin
                  if (w[11]) begin
                     if (w[5:3] == 3'd7) return (n < 3) ? kind_fail(ST_SHORT) : kind_ok(OP_CAS2);
                     return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_CAS);
                  end
                  if (n < 2) return kind_fail(ST_SHORT);
                  if (w[10:9] == 2'd3) return kind_fail(ST_INV);
                  return kind_ok(x[11] ? OP_CHK2 : OP_CMP2);
               end
               // Immediate operand length follows the size field; long takes two words.
               need = (w[7:6] == 2'd0) ? 3'd2 : ({1'b0, w[7:6]} + 3'd1);
               case (w[11:9])
                  3'd0: base = OP_ORI;
                  3'd1: base = OP_ANDI;
                  3'd2: base = OP_SUBI;
                  3'd3: base = OP_ADDI;
                  3'd5: base = OP_EORI;
                  3'd6: base = OP_CMPI;
                  3'd7: return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_MOVES);
                  default: return kind_fail(ST_UNK);
               endcase
               if (n < need) return kind_fail(ST_SHORT);
               return kind_ok(base);
            end
            4'h1, 4'h2, 4'h3:
               return kind_ok((w[8:6] == 3'd1) ? OP_MOVEA : OP_MOVE);
            4'h4: begin
               if (w[8]) begin
                  if (w[7:6] == 2'd3) return kind_ok((w[5:3] == 3'd0) ? OP_EXTB : OP_LEA);
                  return w[6] ? kind_fail(ST_UNK) : kind_ok(OP_CHK);
               end
               if (!w[11]) begin
                  if (w[7:6] == 2'd3) return kind_ok(OP_MOVE);
                  return kind_ok(op_type'(OP_NEGX + w[10:9]));
               end
               if (w[9] && !w[10]) begin
                  if (w[7:6] != 2'd3) return kind_ok(OP_TST);
                  return kind_ok((w[5:0] == ILLEGAL_LOW) ? OP_ILLEGAL : OP_TAS);
               end
               if (w[9]) begin
                  case (w[7:6])
                     2'd2: return kind_ok(OP_JSR);
                     2'd3: return kind_ok(OP_JMP);
                     2'd0: return kind_fail(ST_UNK);
                     default: ;
                  endcase
                  case (w[5:4])
                     2'd0: return kind_ok(OP_TRAP);
                     2'd1: begin
                        if (w[3]) return kind_ok(OP_UNLK);
                        return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_LINK);
                     end
                     2'd2: return kind_ok(OP_MOVE);
                     default: begin
                        if (w[3]) begin
                           if (w[2:1] != 2'd1) return kind_fail(ST_UNK);
                           return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_MOVEC);
                        end
                        case (w[2:0])
                           3'd0: return kind_ok(OP_RESET);
                           3'd1: return kind_ok(OP_NOP);
                           3'd2: return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_STOP);
                           3'd3: return kind_ok(OP_RTE);
                           3'd4: return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_RTD);
                           3'd5: return kind_ok(OP_RTS);
                           default: return kind_fail(ST_UNK);
                        endcase
                     end
                  endcase
               end
               if (w[7]) begin
                  if (w[5:3] == 3'd0) return kind_ok(OP_EXT);
                  return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_MOVEM);
               end
               if (w[10]) begin
                  // Long multiply and divide: bit 6 picks divide, extension bit 11 signed.
                  if (n < 2) return kind_fail(ST_SHORT);
                  if (x[11]) return kind_ok(w[6] ? OP_DIVS : OP_MULS);
                  return kind_ok(w[6] ? OP_DIVU : OP_MULU);
               end
               if (w[6]) begin
                  if (w[5:3] == 3'd0) return kind_ok(OP_SWAP);
                  return kind_ok((w[5:3] == 3'd1) ? OP_BKPT : OP_PEA);
               end
               if (w[5:3] == 3'd1) return (n < 3) ? kind_fail(ST_SHORT) : kind_ok(OP_LINK);
               return kind_ok(OP_NBCD);
            end
            4'h5: begin
               if (w[7:6] != 2'd3) return kind_ok(w[8] ? OP_SUBQ : OP_ADDQ);
               if (w[5:3] == 3'd1) return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_DBCC);
               if (w[5:3] != 3'd7) return kind_ok(OP_SCC);
               case (w[2:0])
                  3'd2: return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_TRAPCC);
                  3'd3: return (n < 3) ? kind_fail(ST_SHORT) : kind_ok(OP_TRAPCC);
                  3'd4: return kind_ok(OP_TRAPCC);
                  default: return kind_fail(ST_UNK);
               endcase
            end
            4'h6: begin
               // Condition fourteen carries TRAPV and RTR in its displacement byte.
               if (w[11:8] == 4'd14) begin
                  if (w[7:0] == DISP_TRAPV) return kind_ok(OP_TRAPV);
                  if (w[7:0] == DISP_RTR) return kind_ok(OP_RTR);
                  return kind_fail(ST_UNK);
               end
               if (w[7:0] == 8'h00 && n < 2) return kind_fail(ST_SHORT);
               if (w[7:0] == DISP_LONG && n < 3) return kind_fail(ST_SHORT);
               if (w[11:8] == 4'd0) return kind_ok(OP_BRA);
               return kind_ok((w[11:8] == 4'd1) ? OP_BSR : OP_BCC);
            end
            4'h7:
               return w[8] ? kind_fail(ST_UNK) : kind_ok(OP_MOVEQ);
            4'h8, 4'hC: begin
               if (w[7:6] == 2'd3) begin
                  if (w[8]) return kind_ok(w[14] ? OP_MULS : OP_DIVS);
                  return kind_ok(w[14] ? OP_MULU : OP_DIVU);
               end
               if (w[10] && w[5:4] == 2'd0) begin
                  if (w[8:6] == 3'd4) return kind_ok(w[14] ? OP_ABCD : OP_SBCD);
                  if (w[14]) return w[8] ? kind_ok(OP_EXG) : kind_fail(ST_UNK);
                  if (w[8:6] == 3'd5) return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_PACK);
                  if (w[8:6] == 3'd6) return (n < 2) ? kind_fail(ST_SHORT) : kind_ok(OP_UNPK);
                  return kind_fail(ST_UNK);
               end
               return kind_ok(w[14] ? OP_AND : OP_OR);
            end
            4'h9, 4'hD: begin
               base = w[14] ? OP_ADDA : OP_SUBA;
               if (w[7:6] == 2'd3) return kind_ok(base);
               if (w[5:4] == 2'd0 && w[8]) return kind_ok(op_type'(base + 7'd1));
               return kind_ok(op_type'(base + 7'd2));
            end
            4'hB: begin
               if (w[7:6] == 2'd3) return kind_ok(OP_CMPA);
               if (!w[8]) return kind_ok(OP_CMP);
               return kind_ok((w[5:3] == 3'd1) ? OP_CMPM : OP_EOR);
            end
            4'hE: begin
               // Memory shifts with bit 11 set need a second word; the others
               // fall into the register-shift kinds.
               if (w[7:6] == 2'd3 && w[11]) begin
                  if (n < 2) return kind_fail(ST_SHORT);
                  base = w[8] ? OP_ASL_M : OP_ASR_M;
                  return kind_ok(op_type'(base + w[10:9]));
               end
               base = w[8] ? OP_ASL_R : OP_ASR_R;
               if (w[7:6] == 2'd3) return kind_ok(op_type'(base + w[10:9]));
               return kind_ok(op_type'(base + w[4:3]));
            end
            4'hF: begin
               if (w[11:9] == 3'd0) begin
                  // Coprocessor zero is the MMU; the extension word names the operation.
                  if (n < 2) return kind_fail(ST_SHORT);
                  if (w[8:6] != 3'd0) return kind_fail(ST_UNK);
                  case (x[15:13])
                     3'd1: begin
                        if (x[12:10] == 3'd0) return kind_ok(x[9] ? OP_PMOVE_RD : OP_PMOVE_WR);
                        return kind_ok((x[7:5] == 3'd1) ? OP_PFLUSHA : OP_PFLUSH);
                     end
                     3'd2: return kind_ok(x[8] ? OP_PTEST_RD : OP_PTEST_WR);
                     3'd4: return kind_ok(x[9] ? OP_PLOAD_RD : OP_PLOAD_WR);
                     default: return kind_fail(ST_UNK);
                  endcase
               end
               case (w[8:6])
                  3'd0: return kind_ok(OP_CPGEN);
                  3'd1: begin
                     if (n < 2) return kind_fail(ST_SHORT);
                     if (w[5:3] == 3'd1) return kind_ok(OP_CPDBCC);
                     return kind_ok((w[5:3] == 3'd7) ? OP_CPTRAPCC : OP_CPSCC);
                  end
                  3'd2, 3'd3: return kind_ok(OP_CPBCC);
                  3'd4: return kind_ok(OP_CPSAVE);
                  3'd5: return kind_ok(OP_CPRESTORE);
                  default: return kind_fail(ST_UNK);
               endcase
            end
            default: return kind_fail(ST_UNK);
         endcase
         return kind_fail(ST_UNK);
      endfunction

      function void note_request(word_type w, word_type x, count_type n);
         pending_decode_type e;
         e.w = w;
         e.x = x;
         e.n = n;
         e.want = classify_opcode(w, x, n);
         pending.push_back(e);
         accepted++;
      endfunction

      function void check_response(op_code_type op, logic [1:0] st);
         pending_decode_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("decode error: response op %0d status %0d with no request pending",
                        op, st);
            return;
         end
         e = pending.pop_front();
         if (op !== op_code_type'(e.want.kind) || st !== 2'(e.want.st)) begin
            mismatches++;
            if (mismatches <= 10)
               $display("decode error: word %h ext %h n %0d: expected op %0d status %0d, got op %0d status %0d",
                        e.w, e.x, e.n, e.want.kind, e.want.st, op, st);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   word_type    req_first_word = '0;
   word_type    req_second_word = '0;
   count_type   req_words_available = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   op_code_type rsp_operation;
   logic [1:0]  rsp_status;

   opclass_scoreboard sb;

   cisc_opcode_class_decoder u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_first_word      (req_first_word),
      .req_second_word     (req_second_word),
      .req_words_available (req_words_available),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_operation       (rsp_operation),
      .rsp_status          (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the run. Even with the longest gaps on both sides a
   // correct run needs only a fraction of this.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Both monitors sample at the rising edge, so they see the values that
   // the block saw when it decided on the transfer.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_first_word, req_second_word, req_words_available);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_operation, rsp_status);
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Opcode words: half fully random, half drawn from bit patterns that
   // steer into the deep corners of the tree, with the free bits random.
   function automatic word_type random_opcode();
      word_type r;
      word_type care;
      word_type fixed;
      r = word_type'($urandom);
      if ($urandom_range(0, 1) == 0) return r;
      case ($urandom_range(0, 30))
         0:  begin care = 16'hFF00; fixed = 16'h0800; end   // static bit operations
         1:  begin care = 16'hFF00; fixed = 16'h0B00; end   // dynamic bit operations via the XOR test
         2:  begin care = 16'hF8C0; fixed = 16'h08C0; end   // CAS
         3:  begin care = 16'hF8F8; fixed = 16'h08F8; end   // CAS2
         4:  begin care = 16'hF8C0; fixed = 16'h00C0; end   // CMP2 and CHK2
         5:  begin care = 16'hF100; fixed = 16'h0000; end   // immediates
         6:  begin care = 16'hF100; fixed = 16'h4100; end   // CHK, LEA, EXTB
         7:  begin care = 16'hFFC0; fixed = 16'h4E40; end   // TRAP, LINK, UNLK, MOVE USP
         8:  begin care = 16'hFFF0; fixed = 16'h4E70; end   // RESET through RTS
         9:  begin care = 16'hFFF8; fixed = 16'h4E78; end   // MOVEC
         10: begin care = 16'hFF80; fixed = 16'h4E80; end   // JSR and JMP
         11: begin care = 16'hFF00; fixed = 16'h4A00; end   // TST and TAS
         12: begin care = 16'hFFFF; fixed = 16'h4AFC; end   // ILLEGAL
         13: begin care = 16'hFB00; fixed = 16'h4800; end   // EXT, MOVEM, long MUL and DIV
         14: begin care = 16'hF900; fixed = 16'h4000; end   // NEGX, CLR, NEG, NOT
         15: begin care = 16'hFFC0; fixed = 16'h4C00; end   // long multiply
         16: begin care = 16'hF0C0; fixed = 16'h50C0; end   // Scc and DBcc
         17: begin care = 16'hF0F8; fixed = 16'h50F8; end   // TRAPcc
         18: begin care = 16'hFF00; fixed = 16'h6E00; end   // branch condition fourteen
         19: begin care = 16'hFFFE; fixed = 16'h6E76; end   // TRAPV and RTR
         20: begin care = 16'hF0FF; fixed = 16'h6000; end   // word displacement branches
         21: begin care = 16'hF0FF; fixed = 16'h60FF; end   // long displacement branches
         22: begin care = 16'hB430; fixed = 16'h8400; end   // ABCD, SBCD, EXG
         23: begin care = 16'hF0C0; fixed = 16'hE0C0; end   // memory shifts
         24: begin care = 16'hFFC0; fixed = 16'hF000; end   // MMU operations
         25: begin care = 16'hF1C0; fixed = 16'hF040; end   // coprocessor DBcc, Scc, TRAPcc
         26: begin care = 16'hF138; fixed = 16'hB108; end   // CMPM
         27: begin care = 16'hFFF8; fixed = 16'h4808; end   // LINK long
         28: begin care = 16'hFFC0; fixed = 16'h4840; end   // SWAP, BKPT, PEA
         29: begin care = 16'hF530; fixed = 16'h8500; end   // PACK and UNPK
         default: begin care = 16'hF000; fixed = 16'hA000; end  // line A
      endcase
      return (r & ~care) | fixed;
   endfunction

   // The extension word only matters for a few kinds; half of the time its
   // top bits are forced onto the MMU operation groups.
   function automatic word_type random_extension();
      word_type r;
      r = word_type'($urandom);
      if ($urandom_range(0, 1) == 0) return r;
      case ($urandom_range(0, 2))
         0: r[15:13] = 3'd1;
         1: r[15:13] = 3'd2;
         default: r[15:13] = 3'd4;
      endcase
      if ($urandom_range(0, 1) == 0) r[12:10] = 3'd0;
      return r;
   endfunction

   function automatic count_type random_count();
      if ($urandom_range(0, 3) == 0) return count_type'($urandom_range(0, 7));
      return count_type'($urandom_range(1, 3));
   endfunction

   // Presents one request and holds it until the transfer happens. It is
   // called right after a rising edge, and valid is raised by the same
   // assignment that carries the payload.
   task automatic send_decode(input word_type w, input word_type x, input count_type n);
      req_first_word      <= w;
      req_second_word     <= x;
      req_words_available <= n;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_pause();
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic offer(input word_type w, input word_type x, input count_type n);
      send_decode(w, x, n);
      sender_pause();
   endtask

   // Response side. Ready toggles at random, with occasional long runs of
   // ready, and once a long hold-off while the request side keeps offering,
   // so that both registers fill and req_ready drops.
   initial begin
      int unsigned gap;
      int unsigned run;
      bit          held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 19) == 0) ? 60 : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (!held && sb.accepted >= 400) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: field extremes and the documented special cases.
      offer(16'h0000, 16'h0000, 3'd0);   // no words present at all
      offer(16'hFFFF, 16'hFFFF, 3'd7);
      offer(16'h0000, 16'hFFFF, 3'd7);   // ORI byte
      offer(16'h0800, 16'h0000, 3'd1);   // static BTST without its second word
      offer(16'h0B00, 16'h0000, 3'd1);   // dynamic bit operation from the XOR test
      offer(16'h06C0, 16'h0000, 3'd2);   // CMP2 with size three is invalid
      offer(16'h06C0, 16'h0000, 3'd1);   // the length check comes before that
      offer(16'h08FC, 16'h0000, 3'd2);   // static BSET with its second word; the bit test comes before CAS2
      offer(16'h0900, 16'h0000, 3'd7);   // immediate group four off the bit path
      offer(16'h4C00, 16'h0800, 3'd2);   // long multiply, signed
      offer(16'h4C40, 16'h0000, 3'd2);   // long divide, unsigned
      offer(16'hA123, 16'h0000, 3'd7);   // line A
      offer(16'hF040, 16'h0000, 3'd2);   // MMU group with bits 8..6 set
      offer(16'hF040, 16'h0000, 3'd1);
      offer(16'h4AFC, 16'h0000, 3'd1);   // ILLEGAL
      offer(16'h6E76, 16'h0000, 3'd1);   // TRAPV
      offer(16'h6E77, 16'h0000, 3'd1);   // RTR
      offer(16'h6000, 16'h0000, 3'd1);   // word branch, one word short
      offer(16'h60FF, 16'h0000, 3'd2);   // long branch, one word short
      offer(16'h61FF, 16'h0000, 3'd3);   // BSR long
      offer(16'h4808, 16'h0000, 3'd2);   // LINK long needs three words
      offer(16'h4E72, 16'h0000, 3'd1);   // STOP without its operand
      offer(16'hF000, 16'h2200, 3'd2);   // PMOVE
      offer(16'hF278, 16'h0000, 3'd2);   // coprocessor TRAPcc
      offer(16'h7100, 16'h0000, 3'd1);   // MOVEQ with bit 8 set
      offer(16'hE8C0, 16'h0000, 3'd1);   // memory shift with bit 11, one word

      // Random requests. The first stretch of every 200 runs back to back.
      for (int i = 0; i < 1050; i++) begin
         send_decode(random_opcode(), random_extension(), random_count());
         if (i % 200 >= 30) sender_pause();
      end
      req_valid <= 1'b0;

      // Let every prediction drain, then keep watching for any stray response
      // transfer to show up.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
